/* src/aazc_pkg.sv */
// ----------------------------------------------------------------------------
// aazc_pkg: shared types and constants of the apnea alarm
// Field widths, register codes, reset values and the structs that pass
// between the crossing window and the tick logic.
// ----------------------------------------------------------------------------
package aazc_pkg;

  // Field widths
  localparam int unsigned SampleW = 12;
  localparam int unsigned SpoW    = 10;
  localparam int unsigned CountW  = 10;
  localparam int unsigned SecW    = 8;
  localparam int unsigned LevelW  = 2;
  localparam int unsigned CfgW    = 12;

  // Default history depth in samples
  localparam int unsigned WindowDef = 750;

  // Register reset values
  localparam logic [SampleW-1:0] MidlineRst   = 12'd2048;
  localparam logic [SpoW-1:0]    SpoLowRst    = 10'd880;
  localparam logic [CountW-1:0]  MinCrossRst  = 10'd1;
  localparam logic [SecW-1:0]    AlertSecsRst = 8'd20;

  // Severity thresholds and counter ceiling
  localparam logic [SecW-1:0] Level1Secs = 8'd20;
  localparam logic [SecW-1:0] Level2Secs = 8'd30;
  localparam logic [SecW-1:0] SecMax     = 8'hFF;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_MIDLINE    = 2'd0,
    CFG_SPO2_LOW   = 2'd1,
    CFG_MIN_CROSS  = 2'd2,
    CFG_ALERT_SECS = 2'd3
  } cfg_idx_e;

  typedef enum logic [LevelW-1:0] {
    LVL_NORMAL = 2'd0,
    LVL_LONG   = 2'd1,
    LVL_SEVERE = 2'd2
  } level_e;

  // Tick thresholds seen by the tick logic
  typedef struct packed {
    logic [SpoW-1:0]   spo2_low;
    logic [CountW-1:0] min_cross;
    logic [SecW-1:0]   alert_secs;
  } tick_cfg_t;

  // Tick leaving the window stage, with the crossing count over the history window
  typedef struct packed {
    logic              valid;
    logic [SpoW-1:0]   spo2;
    logic [CountW-1:0] crossings;
  } tick_req_t;

endpackage

/* src/aazc_if.sv */
// ----------------------------------------------------------------------------
// aazc_if: input and result channels of the apnea alarm
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface aazc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [aazc_pkg::SampleW-1:0] sample;
  logic [aazc_pkg::SpoW-1:0]    spo2_tenths;

  modport source (output valid, op, sample, spo2_tenths, input ready);
  modport sink   (input valid, op, sample, spo2_tenths, output ready);
endinterface

interface aazc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        alert;
  logic [aazc_pkg::SecW-1:0]   apnea_seconds;
  logic [aazc_pkg::LevelW-1:0] apnea_level;
  logic [aazc_pkg::CountW-1:0] crossings;
  logic                        apnea_now;

  modport source (output valid, alert, apnea_seconds, apnea_level, crossings, apnea_now,
                  input ready);
  modport sink   (input valid, alert, apnea_seconds, apnea_level, crossings, apnea_now,
                  output ready);
endinterface

/* src/aazc_ram.sv */
// ----------------------------------------------------------------------------
// aazc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module aazc_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/aazc_window.sv */
// ----------------------------------------------------------------------------
// aazc_window: crossing history ring and running crossing count
// Reads the oldest history bit on a sample transfer, then writes the new
// bit back and updates the count in the next cycle. Ticks pass through in order.
// ----------------------------------------------------------------------------
module aazc_window #(
  parameter int unsigned Window = aazc_pkg::WindowDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  aazc_in_if.sink                      in_i,
  input  logic [aazc_pkg::SampleW-1:0] midline_i,
  input  logic                         hold_i,
  output aazc_pkg::tick_req_t          tick_o
);
  import aazc_pkg::*;

  localparam int unsigned PosW = $clog2(Window);
  localparam logic [PosW-1:0] PosLast = PosW'(Window - 1);

  logic            accept;
  logic            is_sample;
  logic            above;
  logic            cross_bit;
  logic            pos_wrap;

  logic [PosW-1:0] pos_q, pos_d;
  logic            wrapped_q, wrapped_d;
  logic            last_above_q, last_above_d;
  logic [CountW-1:0] count_q, count_d;

  logic            s2_valid_q, s2_valid_d;
  op_e             s2_op_q;
  logic            s2_bit_q;
  logic [PosW-1:0] s2_pos_q;
  logic            s2_old_ok_q;
  logic [SpoW-1:0] s2_spo2_q;

  logic            s2_sample;
  logic            old_bit;
  logic            ram_rdata;

  assign in_i.ready = !hold_i;
  assign accept     = in_i.valid && in_i.ready;
  assign is_sample  = accept && (op_e'(in_i.op) == OP_SAMPLE);

  // Classify the sample against the midline
  assign above     = (in_i.sample >= midline_i);
  assign cross_bit = above ^ last_above_q;
  assign pos_wrap  = (pos_q == PosLast);

  // Advance the write position on each sample
  always_comb begin
    pos_d        = pos_q;
    wrapped_d    = wrapped_q;
    last_above_d = last_above_q;
    if (is_sample) begin
      pos_d        = pos_wrap ? '0 : pos_q + PosW'(1);
      wrapped_d    = wrapped_q | pos_wrap;
      last_above_d = above;
    end
  end

  // Second stage: hold while the tick logic stalls
  assign s2_valid_d = hold_i ? s2_valid_q : accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      wrapped_q    <= 1'b0;
      last_above_q <= 1'b0;
      count_q      <= '0;
      s2_valid_q   <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      wrapped_q    <= wrapped_d;
      last_above_q <= last_above_d;
      count_q      <= count_d;
      s2_valid_q   <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_op_q     <= op_e'(in_i.op);
      s2_bit_q    <= cross_bit;
      s2_pos_q    <= pos_q;
      s2_old_ok_q <= wrapped_q;
      s2_spo2_q   <= in_i.spo2_tenths;
    end
  end

  // Entries not yet written since reset read as zero
  assign s2_sample = s2_valid_q && (s2_op_q == OP_SAMPLE);
  assign old_bit   = s2_old_ok_q & ram_rdata;

  // Drop the oldest bit, add the newest
  always_comb begin
    count_d = count_q;
    if (s2_sample) begin
      count_d = count_q - CountW'(old_bit) + CountW'(s2_bit_q);
    end
  end

  aazc_ram #(
    .Width (1),
    .Depth (Window)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (s2_sample),
    .waddr_i (s2_pos_q),
    .wdata_i (s2_bit_q),
    .re_i    (is_sample),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  assign tick_o.valid     = s2_valid_q && (s2_op_q == OP_TICK);
  assign tick_o.spo2      = s2_spo2_q;
  assign tick_o.crossings = count_q;

  // The count never exceeds the number of history entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= Window)
    else $error("crossing count exceeds window");

  // Only a tick may stall the second stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_i |-> tick_o.valid)
    else $error("stall without a pending tick");

  // A stalled tick keeps its slot and accepts nothing new
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_i |=> s2_valid_q && $stable(s2_spo2_q) && $stable(count_q))
    else $error("stalled tick lost or count moved");

endmodule

/* src/aazc_tick.sv */
// ----------------------------------------------------------------------------
// aazc_tick: apnea decision, seconds counter and result register
// Decides apnea per tick, runs the saturating counter, raises alerts and
// holds the result until the result channel takes it.
// ----------------------------------------------------------------------------
module aazc_tick (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aazc_pkg::tick_req_t tick_i,
  input  aazc_pkg::tick_cfg_t cfg_i,
  output logic                hold_o,
  aazc_out_if.source          out_o
);
  import aazc_pkg::*;

  logic            fire;
  logic            apnea;
  logic            alert;
  logic [SecW-1:0] secs;
  level_e          level;

  logic [SecW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            alert_q;
  logic [SecW-1:0] secs_q;
  level_e          level_q;
  logic [CountW-1:0] cross_q;
  logic            apnea_q;

  // Stall the tick while an untaken result sits in the register
  assign hold_o = tick_i.valid && out_valid_q && !out_o.ready;
  assign fire   = tick_i.valid && !hold_o;

  // Apnea decision and counter update
  always_comb begin
    apnea = (tick_i.spo2 < cfg_i.spo2_low) || (tick_i.crossings < cfg_i.min_cross);
    if (!apnea) begin
      secs = '0;
    end else if (cnt_q == SecMax) begin
      secs = cnt_q;
    end else begin
      secs = cnt_q + SecW'(1);
    end
    alert = apnea && (secs >= cfg_i.alert_secs);
    if (secs > Level2Secs) begin
      level = LVL_SEVERE;
    end else if (secs > Level1Secs) begin
      level = LVL_LONG;
    end else begin
      level = LVL_NORMAL;
    end
    cnt_d = cnt_q;
    if (fire) begin
      cnt_d = alert ? '0 : secs;
    end
  end

  // Result register valid: load on a tick, drop on a transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      alert_q <= alert;
      secs_q  <= secs;
      level_q <= level;
      cross_q <= tick_i.crossings;
      apnea_q <= apnea;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.alert         = alert_q;
  assign out_o.apnea_seconds = secs_q;
  assign out_o.apnea_level   = level_q;
  assign out_o.crossings     = cross_q;
  assign out_o.apnea_now     = apnea_q;

  // An alert restarts the counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && alert |=> cnt_q == '0)
    else $error("counter not restarted after alert");

  // An alert only comes with apnea and a nonzero duration
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && alert_q |-> apnea_q && (secs_q != '0))
    else $error("alert without apnea");

  // No apnea means a zero duration
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !apnea_q |-> (secs_q == '0) && (level_q == LVL_NORMAL))
    else $error("duration without apnea");

endmodule

/* src/apnea_alarm_zero_crossing.sv */
// A tick passes the second window stage and the result register before it
// is offered; samples give no result and update the crossing count from the
// second stage. Throughput: one item per cycle while no tick stalls, set by
// the one-read one-write history RAM whose read-modify-write spans two stages.
// Reset: control state clears at once; the history RAM is not swept, a wrap
// flag makes entries not yet written since reset count as zero.
// ----------------------------------------------------------------------------
// apnea_alarm_zero_crossing: apnea alarm from bed-sensor crossings and SpO2
// Holds the configuration registers and joins the crossing window to the
// tick logic.
// ----------------------------------------------------------------------------
module apnea_alarm_zero_crossing #(
  parameter int unsigned Window = aazc_pkg::WindowDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [aazc_pkg::CfgW-1:0] cfg_data_i,
  aazc_in_if.sink                   in_i,
  aazc_out_if.source                out_o
);
  import aazc_pkg::*;

  logic [SampleW-1:0] midline_q, midline_d;
  tick_cfg_t          tcfg_q, tcfg_d;
  tick_req_t          tick_req;
  logic               hold;

  // Configuration register writes
  always_comb begin
    midline_d = midline_q;
    tcfg_d    = tcfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIDLINE:    midline_d         = cfg_data_i[SampleW-1:0];
        CFG_SPO2_LOW:   tcfg_d.spo2_low   = cfg_data_i[SpoW-1:0];
        CFG_MIN_CROSS:  tcfg_d.min_cross  = cfg_data_i[CountW-1:0];
        CFG_ALERT_SECS: tcfg_d.alert_secs = cfg_data_i[SecW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      midline_q         <= MidlineRst;
      tcfg_q.spo2_low   <= SpoLowRst;
      tcfg_q.min_cross  <= MinCrossRst;
      tcfg_q.alert_secs <= AlertSecsRst;
    end else begin
      midline_q <= midline_d;
      tcfg_q    <= tcfg_d;
    end
  end

  aazc_window #(
    .Window (Window)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .midline_i (midline_q),
    .hold_i    (hold),
    .tick_o    (tick_req)
  );

  aazc_tick u_tick (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick_req),
    .cfg_i  (tcfg_q),
    .hold_o (hold),
    .out_o  (out_o)
  );

endmodule

/* dv/apnea_alarm_zero_crossing_tb.sv */
// ----------------------------------------------------------------------------
// apnea_alarm_zero_crossing_tb: testbench of the apnea alarm
// Drives sensor samples and one-second ticks through the input channel and
// checks every tick report against a cycle-free predictor of the crossing
// window and the apnea counter. Registers change only while the block is
// idle; in two of three pressure modes both channel sides idle at random.
// ----------------------------------------------------------------------------
module apnea_alarm_zero_crossing_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aazc_pkg::*;

  localparam int unsigned Depth        = WindowDef;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned TargetItems  = 1700;
  localparam int unsigned MaxShown     = 10;

  typedef struct packed {
    op_e               op;
    logic [SampleW-1:0] sample;
    logic [SpoW-1:0]    spo2;
  } reading_t;

  typedef struct packed {
    logic              alert;
    logic [SecW-1:0]   secs;
    level_e            level;
    logic [CountW-1:0] crossings;
    logic              apnea_now;
  } report_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  cfg_idx_e          cfg_idx;
  logic [CfgW-1:0]   cfg_data;

  aazc_in_if  in_if ();
  aazc_out_if out_if ();

  apnea_alarm_zero_crossing DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Predicted registers
  logic [SampleW-1:0] mid_level;
  logic [SpoW-1:0]    spo2_floor;
  logic [CountW-1:0]  cross_floor;
  logic [SecW-1:0]    alert_limit;

  // Predicted window and counter state
  bit                 win_hist [Depth];
  int unsigned        win_pos;
  logic [CountW-1:0]  win_count;
  logic               prev_above;
  logic [SecW-1:0]    apnea_run;

  reading_t queued_readings [$];
  report_t  expected_reports [$];
  reading_t active_reading;

  int send_idle_pct;
  int recv_idle_pct;
  int total_items;
  int n_samples, n_ticks, n_reports, n_alerts, n_severe, n_settings;
  int n_fail;

  always #6 clk_i = ~clk_i;

  // Advance the predicted window or counter by one accepted reading
  task automatic track_reading(input reading_t rd);
    logic    above;
    logic    cross_bit;
    logic    apnea;
    report_t rep;
    if (rd.op == OP_SAMPLE) begin
      above      = (rd.sample >= mid_level);
      cross_bit  = above ^ prev_above;
      win_count  = win_count - win_hist[win_pos] + cross_bit;
      win_hist[win_pos] = cross_bit;
      win_pos    = (win_pos == Depth - 1) ? 0 : win_pos + 1;
      prev_above = above;
      n_samples++;
    end else begin
      apnea = (rd.spo2 < spo2_floor) || (win_count < cross_floor);
      if (!apnea) begin
        apnea_run = '0;
      end else if (apnea_run != SecMax) begin
        apnea_run = apnea_run + 1'b1;
      end
      rep.alert     = apnea && (apnea_run >= alert_limit);
      rep.secs      = apnea_run;
      rep.level     = (apnea_run > Level2Secs) ? LVL_SEVERE :
                      (apnea_run > Level1Secs) ? LVL_LONG : LVL_NORMAL;
      rep.crossings = win_count;
      rep.apnea_now = apnea;
      if (rep.alert) apnea_run = '0;
      expected_reports.push_back(rep);
      n_ticks++;
    end
  endtask

  task automatic flag_failure(input string msg);
    n_fail++;
    if (n_fail <= MaxShown) $display("ERROR: %s", msg);
  endtask

  // Driver: present queued readings, insert random idle cycles
  always @(posedge clk_i) begin : drive_readings
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) track_reading(active_reading);
      if (!in_if.valid || in_if.ready) begin
        if (queued_readings.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          active_reading     = queued_readings.pop_front();
          in_if.valid       <= 1'b1;
          in_if.op          <= active_reading.op;
          in_if.sample      <= active_reading.sample;
          in_if.spo2_tenths <= active_reading.spo2;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each report transfer against the oldest prediction
  always @(posedge clk_i) begin : check_reports
    report_t want;
    report_t got;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.alert     = out_if.alert;
        got.secs      = out_if.apnea_seconds;
        got.level     = level_e'(out_if.apnea_level);
        got.crossings = out_if.crossings;
        got.apnea_now = out_if.apnea_now;
        n_reports++;
        if (expected_reports.size() == 0) begin
          flag_failure($sformatf("report %0d arrived with none predicted", n_reports));
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            flag_failure($sformatf(
              "report %0d: expected alert=%0d secs=%0d level=%0d cross=%0d apnea=%0d",
              n_reports, want.alert, want.secs, want.level, want.crossings,
              want.apnea_now));
            if (n_fail <= MaxShown)
              $display("       got      alert=%0d secs=%0d level=%0d cross=%0d apnea=%0d",
                       got.alert, got.secs, got.level, got.crossings, got.apnea_now);
          end else begin
            if (got.alert) n_alerts++;
            if (got.level == LVL_SEVERE) n_severe++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Write one register and mirror it; upper data bits carry noise
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] val);
    logic [CfgW-1:0] data;
    data = val;
    case (idx)
      CFG_MIDLINE: begin
        mid_level = val;
      end
      CFG_SPO2_LOW: begin
        data[CfgW-1:SpoW] = 2'($urandom_range(3));
        spo2_floor = val[SpoW-1:0];
      end
      CFG_MIN_CROSS: begin
        data[CfgW-1:CountW] = 2'($urandom_range(3));
        cross_floor = val[CountW-1:0];
      end
      default: begin
        data[CfgW-1:SecW] = 4'($urandom_range(15));
        alert_limit = val[SecW-1:0];
      end
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
  endtask

  task automatic set_registers(input int mid, input int low, input int minc, input int lim);
    write_reg(CFG_MIDLINE, CfgW'(mid));
    write_reg(CFG_SPO2_LOW, CfgW'(low));
    write_reg(CFG_MIN_CROSS, CfgW'(minc));
    write_reg(CFG_ALERT_SECS, CfgW'(lim));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Hold until every reading is through and every report is back, then settle
  task automatic wait_idle();
    while (queued_readings.size() != 0 || in_if.valid || expected_reports.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Pick the idle mix from how far the stimulus has come
  task automatic pick_idling();
    if (total_items < TargetItems / 3) begin
      send_idle_pct = 36;
      recv_idle_pct = 69;
    end else if (total_items < 2 * TargetItems / 3) begin
      send_idle_pct = 69;
      recv_idle_pct = 36;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic push_reading(input op_e op, input int sample, input int spo2);
    reading_t rd;
    rd.op     = op;
    rd.sample = SampleW'(sample);
    rd.spo2   = SpoW'(spo2);
    queued_readings.push_back(rd);
    total_items++;
  endtask

  // Queue one phase of random readings; the field a reading does not use is noise
  task automatic queue_random_phase(input int n, input int tick_pct, input int style,
                                    input int apnea_pct);
    int   run_left;
    int   smp;
    int   spo;
    logic hi_side;
    hi_side  = 1'($urandom_range(1));
    run_left = $urandom_range(40, 2);
    for (int i = 0; i < n; i++) begin
      smp = $urandom_range(4095);
      spo = $urandom_range(1023);
      if ($urandom_range(99) < tick_pct) begin
        if ($urandom_range(99) < apnea_pct) begin
          if (spo2_floor != 0) spo = $urandom_range(spo2_floor - 1, 0);
        end else begin
          spo = $urandom_range(1023, spo2_floor);
        end
        push_reading(OP_TICK, smp, spo);
      end else begin
        if ($urandom_range(19) == 0) begin
          smp = $urandom_range(1) ? 4095 : 0;
        end else if (style != 0) begin
          // style 2 flips side every few samples, like slow breathing
          if (style == 2) begin
            run_left = run_left - 1;
            if (run_left == 0) begin
              hi_side  = ~hi_side;
              run_left = $urandom_range(40, 2);
            end
          end
          if (hi_side || mid_level == 0) smp = $urandom_range(4095, mid_level);
          else smp = $urandom_range(mid_level - 1, 0);
        end
        push_reading(OP_SAMPLE, smp, spo);
      end
    end
  endtask

  initial begin : stimulus
    int mid, low, minc, lim, near;
    // Drive every input known before the first edge
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx            = CFG_MIDLINE;
    cfg_data           = '0;
    in_if.valid        = 1'b0;
    in_if.op           = OP_SAMPLE;
    in_if.sample       = '0;
    in_if.spo2_tenths  = '0;
    out_if.ready       = 1'b0;
    mid_level   = MidlineRst;
    spo2_floor  = SpoLowRst;
    cross_floor = MinCrossRst;
    alert_limit = AlertSecsRst;
    foreach (win_hist[i]) win_hist[i] = 1'b0;
    win_pos    = 0;
    win_count  = '0;
    prev_above = 1'b0;
    apnea_run  = '0;
    total_items = 0;
    n_fail = 0;
    pick_idling();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: first sample above midline crosses, threshold edges
    push_reading(OP_SAMPLE, 4095, 0);
    push_reading(OP_TICK, 0, 1000);
    push_reading(OP_SAMPLE, 0, 1023);
    push_reading(OP_SAMPLE, 2047, 0);
    push_reading(OP_SAMPLE, 2048, 0);
    push_reading(OP_TICK, 4095, 880);
    push_reading(OP_TICK, 0, 879);
    push_reading(OP_TICK, 0, 1023);
    push_reading(OP_TICK, 4095, 0);
    wait_idle();

    // Zero alert limit: every apnea tick alerts; midline moved mid-window
    set_registers(0, 1000, 0, 0);
    push_reading(OP_SAMPLE, 0, 0);
    push_reading(OP_TICK, 0, 0);
    push_reading(OP_TICK, 0, 999);
    push_reading(OP_TICK, 0, 1000);
    push_reading(OP_TICK, 0, 500);
    wait_idle();

    // Crossing floor at its top: apnea from too few crossings
    set_registers(4095, 0, 1023, 3);
    push_reading(OP_SAMPLE, 4094, 0);
    push_reading(OP_SAMPLE, 4095, 0);
    repeat (4) push_reading(OP_TICK, 0, 1023);
    wait_idle();

    // Unbroken apnea up to the largest alert limit
    pick_idling();
    set_registers($urandom_range(4095), 1000, $urandom_range(1023), 255);
    queue_random_phase(270, 100, 0, 100);
    wait_idle();

    while (total_items < TargetItems) begin
      pick_idling();
      case ($urandom_range(3))
        0:       mid = 0;
        1:       mid = 4095;
        2:       mid = 2048;
        default: mid = $urandom_range(4095);
      endcase
      case ($urandom_range(2))
        0:       low = 0;
        1:       low = 1000;
        default: low = $urandom_range(1000);
      endcase
      // Put the crossing floor mostly near the current window count
      near = int'(win_count) + int'($urandom_range(20)) - 10;
      if (near < 0) near = 0;
      case ($urandom_range(4))
        0:       minc = 0;
        1:       minc = 1023;
        2:       minc = $urandom_range(500);
        default: minc = near;
      endcase
      case ($urandom_range(3))
        0:       lim = 1;
        1:       lim = 255;
        2:       lim = $urandom_range(40, 2);
        default: lim = $urandom_range(255, 1);
      endcase
      set_registers(mid, low, minc, lim);
      case ($urandom_range(3))
        0:       queue_random_phase($urandom_range(200, 40), $urandom_range(60, 10),
                                    $urandom_range(2), 100);
        1:       queue_random_phase($urandom_range(200, 40), $urandom_range(60, 10),
                                    $urandom_range(2), 95);
        2:       queue_random_phase($urandom_range(200, 40), $urandom_range(60, 10),
                                    $urandom_range(2), 60);
        default: queue_random_phase($urandom_range(200, 40), $urandom_range(60, 10),
                                    $urandom_range(2), 20);
      endcase
      wait_idle();
    end

    $display("Run covered %0d samples and %0d ticks over %0d register settings.",
             n_samples, n_ticks, n_settings);
    $display("Reports checked: %0d, alerts %0d, severe level %0d, failures %0d.",
             n_reports, n_alerts, n_severe, n_fail);
    if (n_fail == 0 && expected_reports.size() == 0) begin
      $display("PASS apnea_alarm_zero_crossing");
    end else begin
      $display("FAIL apnea_alarm_zero_crossing");
    end
    $finish;
  end

  // Watchdog against a hung handshake
  initial begin : watchdog
    #4_000_000;
    $display("FAIL apnea_alarm_zero_crossing");
    $finish;
  end

endmodule
